// File: hw/rtl/sor_pkg.sv
// Shared types, notice codes and pattern move table for the sonar obstacle reaction block.
`timescale 1ns / 1ps
`default_nettype none
package sor_pkg;

  localparam int MaxNotices = 5;

  localparam logic [2:0] NOTICE_CLEAR   = 3'd0;
  localparam logic [2:0] NOTICE_STOP    = 3'd1;
  localparam logic [2:0] NOTICE_UPDATE  = 3'd2;
  localparam logic [2:0] NOTICE_MOVE    = 3'd3;
  localparam logic [2:0] NOTICE_NORMAL  = 3'd4;
  localparam logic [2:0] NOTICE_RESTART = 3'd5;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_EXEC  = 2'd2;

  localparam logic [3:0] NO_PATTERN = 4'd15;

  localparam logic [2:0] TURN_NONE = 3'd0;
  localparam logic       WAY_AHEAD = 1'b0;
  localparam logic       WAY_BACK  = 1'b1;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [15:0] THRESHOLD_RESET = 16'd500;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] turn_before;
    logic       travel_way;
    logic [2:0] turn_after;
    logic [3:0] pattern;
  } notice_t;

  typedef struct packed {
    logic [2:0]                  cnt;
    notice_t [MaxNotices-1:0]    rec;
  } plan_t;

  typedef struct packed {
    logic       two;
    logic [2:0] after_first;
    logic [2:0] before_second;
  } pat_move_t;

  function automatic notice_t make_notice(input logic [2:0] kind, input logic [2:0] tb,
                                          input logic way, input logic [2:0] ta,
                                          input logic [3:0] pat);
    notice_t r;
    r.kind        = kind;
    r.turn_before = tb;
    r.travel_way  = way;
    r.turn_after  = ta;
    r.pattern     = pat;
    return r;
  endfunction

  function automatic pat_move_t pattern_moves(input logic [3:0] p);
    pat_move_t m;
    case (p)
      4'd0:    m = '{1'b0, 3'd3, 3'd0};
      4'd1:    m = '{1'b1, 3'd0, 3'd3};
      4'd2:    m = '{1'b1, 3'd0, 3'd3};
      4'd3:    m = '{1'b1, 3'd0, 3'd2};
      4'd4:    m = '{1'b1, 3'd0, 3'd2};
      4'd5:    m = '{1'b1, 3'd0, 3'd6};
      4'd6:    m = '{1'b0, 3'd3, 3'd0};
      4'd7:    m = '{1'b1, 3'd0, 3'd3};
      4'd8:    m = '{1'b1, 3'd0, 3'd2};
      4'd9:    m = '{1'b1, 3'd0, 3'd6};
      4'd10:   m = '{1'b1, 3'd0, 3'd6};
      4'd11:   m = '{1'b0, 3'd1, 3'd0};
      4'd12:   m = '{1'b1, 3'd0, 3'd4};
      4'd13:   m = '{1'b1, 3'd0, 3'd4};
      4'd14:   m = '{1'b1, 3'd0, 3'd5};
      default: m = '{1'b0, 3'd0, 3'd0};
    endcase
    return m;
  endfunction

  function automatic logic [3:0] classify(input logic ll, input logic l, input logic f,
                                          input logic r, input logic rr);
    logic [3:0] p;
    if (ll) begin
      if (!l)      p = 4'd4;
      else if (!f) p = 4'd3;
      else if (!r) p = 4'd2;
      else         p = rr ? 4'd0 : 4'd1;
    end else if (l) begin
      if (!f)      p = 4'd8;
      else if (!r) p = 4'd7;
      else         p = rr ? 4'd5 : 4'd6;
    end else if (f) begin
      if (!r)      p = 4'd11;
      else         p = rr ? 4'd9 : 4'd10;
    end else if (r) begin
      p = rr ? 4'd12 : 4'd14;
    end else if (rr) begin
      p = 4'd13;
    end else begin
      p = NO_PATTERN;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sor_front.sv
// Front end: classifies a sonar request, steps both trackers and builds the notice plan.
`timescale 1ns / 1ps
`default_nettype none
module sor_front
  import sor_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        threshold,
  input  wire logic               accept,
  input  wire logic               sonar_side,
  input  wire logic [15:0]        range_a,
  input  wire logic [15:0]        range_b,
  input  wire logic [15:0]        range_c,
  input  wire logic [15:0]        range_d,
  input  wire logic [15:0]        range_e,
  input  wire logic signed [15:0] left_wheel_speed,
  input  wire logic signed [15:0] right_wheel_speed,
  input  wire logic               action_pending,
  input  wire logic [1:0]         action_kind,
  input  wire logic signed [31:0] action_amount,
  output plan_t                   plan
);

  logic [1:0] front_mode, front_mode_next;
  logic [1:0] back_mode, back_mode_next;
  logic [3:0] acted_pattern, acted_pattern_next;

  logic bl, br, bf, bll, brr, any_blocked, back_travel;
  logic [3:0] pat;
  pat_move_t  mv;
  logic [2:0] n;

  assign bl  = range_a < threshold;
  assign br  = range_b < threshold;
  assign bf  = range_c < threshold;
  assign bll = range_d < threshold;
  assign brr = range_e < threshold;
  assign any_blocked = bl | br | bf | bll | brr;
  assign back_travel = action_pending ? (action_kind == 2'd1 && action_amount[31])
                                      : (left_wheel_speed[15] && right_wheel_speed[15]);
  assign pat = classify(bll, bl, bf, br, brr);
  assign mv  = pattern_moves(pat);

  always_comb begin
    plan               = '0;
    front_mode_next    = front_mode;
    back_mode_next     = back_mode;
    acted_pattern_next = acted_pattern;
    for (int i = 0; i < MaxNotices; i++) begin
      plan.rec[i] = make_notice(NOTICE_CLEAR, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
    end
    n = 3'd1;
    if (back_travel) begin
      if (sonar_side && any_blocked) begin
        if (back_mode == MODE_OFF) begin
          plan.rec[n] = make_notice(NOTICE_STOP, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          n = n + 3'd1;
          back_mode_next = MODE_FIRST;
        end else if (back_mode == MODE_FIRST) begin
          plan.rec[n] = make_notice(NOTICE_UPDATE, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          n = n + 3'd1;
          plan.rec[n] = make_notice(NOTICE_MOVE, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          n = n + 3'd1;
          back_mode_next = MODE_EXEC;
        end
        plan.rec[n] = make_notice(NOTICE_NORMAL, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
        n = n + 3'd1;
      end else if (back_mode == MODE_EXEC && !action_pending) begin
        back_mode_next = MODE_OFF;
        plan.rec[n] = make_notice(NOTICE_RESTART, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
        n = n + 3'd1;
      end
    end else begin
      if (!sonar_side && any_blocked) begin
        if (front_mode == MODE_OFF) begin
          plan.rec[n] = make_notice(NOTICE_STOP, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          n = n + 3'd1;
          front_mode_next = MODE_FIRST;
        end else begin
          plan.rec[n] = make_notice(NOTICE_UPDATE, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          n = n + 3'd1;
          if (pat != NO_PATTERN) begin
            if (front_mode == MODE_FIRST) begin
              front_mode_next    = MODE_EXEC;
              acted_pattern_next = pat;
              plan.rec[n] = make_notice(NOTICE_MOVE, TURN_NONE, WAY_BACK, mv.after_first, pat);
              n = n + 3'd1;
              if (mv.two) begin
                plan.rec[n] = make_notice(NOTICE_MOVE, mv.before_second, WAY_AHEAD,
                                          TURN_NONE, pat);
                n = n + 3'd1;
              end
            end else if (front_mode == MODE_EXEC && acted_pattern != pat) begin
              front_mode_next = MODE_OFF;
            end
          end
        end
        plan.rec[n] = make_notice(NOTICE_NORMAL, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
        n = n + 3'd1;
      end else if (front_mode != MODE_OFF && !action_pending) begin
        front_mode_next = MODE_OFF;
        plan.rec[n] = make_notice(NOTICE_RESTART, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
        n = n + 3'd1;
      end
    end
    plan.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_mode    <= MODE_OFF;
      back_mode     <= MODE_OFF;
      acted_pattern <= NO_PATTERN;
    end else if (accept) begin
      front_mode    <= front_mode_next;
      back_mode     <= back_mode_next;
      acted_pattern <= acted_pattern_next;
    end
  end

  a_plan_count: assert property (@(posedge clk) disable iff (rst)
    accept |-> (plan.cnt != 3'd0 && plan.cnt <= 3'(MaxNotices)))
    else $error("plan count out of range");
  a_front_mode: assert property (@(posedge clk) disable iff (rst)
    front_mode != 2'd3 && back_mode != 2'd3)
    else $error("tracker mode corrupted");
  a_exec_pattern: assert property (@(posedge clk) disable iff (rst)
    (front_mode == MODE_EXEC) |-> (acted_pattern != NO_PATTERN))
    else $error("front tracker executing without a pattern");

endmodule
`default_nettype wire

// File: hw/rtl/sor_queue.sv
// Two-entry plan queue between the front end and the notice sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sor_queue
  import sor_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  plan_t     push_plan,
  output logic      not_full,
  input  wire logic pop,
  output logic      not_empty,
  output plan_t     head_plan
);

  plan_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_full  = count != 2'd2;
  assign not_empty = count != 2'd0;
  assign head_plan = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> not_full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire

// File: hw/rtl/sor_back.sv
// Back end: walks a plan one notice per cycle into the output register, holding while out_ready stalls it.
`timescale 1ns / 1ps
`default_nettype none
module sor_back
  import sor_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  plan_t      q_plan,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0] notice_kind,
  output logic [2:0] turn_before,
  output logic       travel_way,
  output logic [2:0] turn_after,
  output logic [3:0] blocked_pattern,
  output logic       last_of_run
);

  plan_t      cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       load, at_last;
  notice_t    out_rec;

  assign load    = cur_valid && (!out_valid || out_ready);
  assign at_last = idx == cur.cnt - 3'd1;
  assign q_pop   = q_valid && (!cur_valid || (load && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= 3'd0;
      end else if (load) begin
        if (at_last) cur_valid <= 1'b0;
        else         idx <= idx + 3'd1;
      end
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_plan;
    if (load) begin
      out_rec     <= cur.rec[idx];
      last_of_run <= at_last;
    end
  end

  assign notice_kind     = out_rec.kind;
  assign turn_before     = out_rec.turn_before;
  assign travel_way      = out_rec.travel_way;
  assign turn_after      = out_rec.turn_after;
  assign blocked_pattern = out_rec.pattern;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < cur.cnt))
    else $error("notice index beyond plan");
  a_first_clear: assert property (@(posedge clk) disable iff (rst)
    (load && idx == 3'd0) |=> (notice_kind == NOTICE_CLEAR))
    else $error("plan does not open with a clear notice");

endmodule
`default_nettype wire

// File: hw/rtl/sonar_obstacle_reaction_fsm.sv
// Top level of the sonar obstacle reaction block: register port, front end, queue, back end.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   in       | in_valid / in_ready       | sonar_side, range_a..e, speeds, action_*
//   out      | out_valid / out_ready     | notice_kind, turns, travel_way, pattern, last
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (obstacle_threshold)
//
// A request is classified and its tracker state updated in the cycle it is accepted.
// Each request yields 1 to 5 notices; the back end emits one notice per cycle while
// out_ready does not stall it. The first notice passes through the queue entry, the
// back end's plan register and the output register; in_ready drops only in reset or when
// both queue entries are full. Reset is synchronous and clears the trackers and the queue.
`timescale 1ns / 1ps
`default_nettype none
module sonar_obstacle_reaction_fsm
  import sor_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               sonar_side,
  input  wire logic [15:0]        range_a,
  input  wire logic [15:0]        range_b,
  input  wire logic [15:0]        range_c,
  input  wire logic [15:0]        range_d,
  input  wire logic [15:0]        range_e,
  input  wire logic signed [15:0] left_wheel_speed,
  input  wire logic signed [15:0] right_wheel_speed,
  input  wire logic               action_pending,
  input  wire logic [1:0]         action_kind,
  input  wire logic signed [31:0] action_amount,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              notice_kind,
  output logic [2:0]              turn_before,
  output logic                    travel_way,
  output logic [2:0]              turn_after,
  output logic [3:0]              blocked_pattern,
  output logic                    last_of_run
);

  logic [15:0] threshold;
  logic        accept, q_not_full, q_not_empty, q_pop;
  plan_t       new_plan, head_plan;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_THRESHOLD) ? {16'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_THRESHOLD) begin
      threshold <= pwdata[15:0];
    end
  end

  assign in_ready = q_not_full && !rst;
  assign accept   = in_valid && in_ready;

  sor_front u_front (
    .clk               (clk),
    .rst               (rst),
    .threshold         (threshold),
    .accept            (accept),
    .sonar_side        (sonar_side),
    .range_a           (range_a),
    .range_b           (range_b),
    .range_c           (range_c),
    .range_d           (range_d),
    .range_e           (range_e),
    .left_wheel_speed  (left_wheel_speed),
    .right_wheel_speed (right_wheel_speed),
    .action_pending    (action_pending),
    .action_kind       (action_kind),
    .action_amount     (action_amount),
    .plan              (new_plan)
  );

  sor_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_plan (new_plan),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_plan (head_plan)
  );

  sor_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_not_empty),
    .q_plan          (head_plan),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .notice_kind     (notice_kind),
    .turn_before     (turn_before),
    .travel_way      (travel_way),
    .turn_after      (turn_after),
    .blocked_pattern (blocked_pattern),
    .last_of_run     (last_of_run)
  );

endmodule
`default_nettype wire

// File: test/tb_sonar_obstacle_reaction_fsm.sv
// Self-checking testbench for the sonar obstacle reaction block: request driver, notice checker.
`timescale 1ns / 1ps
module tb_sonar_obstacle_reaction_fsm;
  import sor_pkg::*;

  localparam logic       SIDE_FRONT = 1'b0;
  localparam logic       SIDE_BACK  = 1'b1;
  localparam logic [1:0] ACT_ROTATE    = 2'd0;
  localparam logic [1:0] ACT_TRANSLATE = 2'd1;
  localparam logic [1:0] ACT_OTHER     = 2'd2;
  localparam logic [1:0] ACT_KIND3     = 2'd3;

  localparam logic [2:0] TURN_R_MIN = 3'd1;
  localparam logic [2:0] TURN_R_MED = 3'd2;
  localparam logic [2:0] TURN_R_MAX = 3'd3;
  localparam logic [2:0] TURN_L_MIN = 3'd4;
  localparam logic [2:0] TURN_L_MED = 3'd5;
  localparam logic [2:0] TURN_L_MAX = 3'd6;

  localparam logic [3:0] P_LLLFRRR = 4'd0;
  localparam logic [3:0] P_LLLFR   = 4'd1;
  localparam logic [3:0] P_LLLF    = 4'd2;
  localparam logic [3:0] P_LLL     = 4'd3;
  localparam logic [3:0] P_LL      = 4'd4;
  localparam logic [3:0] P_LFRRR   = 4'd5;
  localparam logic [3:0] P_LFR     = 4'd6;
  localparam logic [3:0] P_LF      = 4'd7;
  localparam logic [3:0] P_L       = 4'd8;
  localparam logic [3:0] P_FRRR    = 4'd9;
  localparam logic [3:0] P_FR      = 4'd10;
  localparam logic [3:0] P_F       = 4'd11;
  localparam logic [3:0] P_RRR     = 4'd12;
  localparam logic [3:0] P_RR      = 4'd13;
  localparam logic [3:0] P_R       = 4'd14;

  localparam logic [2:0] THRESH_ADDR = 3'(4 * REG_THRESHOLD);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 200;

  typedef struct packed {
    logic        side;
    logic [15:0] range_a, range_b, range_c, range_d, range_e;
    logic [15:0] left_speed, right_speed;
    logic        pending;
    logic [1:0]  kind;
    logic [31:0] amount;
  } sonar_report_t;

  typedef struct packed {
    notice_t note;
    logic    last;
  } expected_notice_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] notice_kind, turn_before, turn_after;
  logic travel_way, last_of_run;
  logic [3:0] blocked_pattern;

  sonar_report_t cur_req = '0;
  sonar_report_t sonar_reports[$];
  expected_notice_t expected_notices[$];

  logic [15:0] thresh_model = THRESHOLD_RESET;
  logic [1:0]  front_trk = MODE_OFF;
  logic [1:0]  back_trk = MODE_OFF;
  logic [3:0]  acted_pat = NO_PATTERN;

  bit in_fire = 1'b0, out_fire = 1'b0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_token = 0, hold_seen = 0, hold_left = 0;
  int idle_cycles = 0, error_cnt = 0, reports_taken = 0, notices_checked = 0;
  int back_moves = 0, settings_run = 1;
  logic [14:0] patterns_hit = '0;

  sonar_obstacle_reaction_fsm dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .sonar_side(cur_req.side),
    .range_a(cur_req.range_a), .range_b(cur_req.range_b), .range_c(cur_req.range_c),
    .range_d(cur_req.range_d), .range_e(cur_req.range_e),
    .left_wheel_speed(cur_req.left_speed), .right_wheel_speed(cur_req.right_speed),
    .action_pending(cur_req.pending), .action_kind(cur_req.kind),
    .action_amount(cur_req.amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .notice_kind(notice_kind), .turn_before(turn_before), .travel_way(travel_way),
    .turn_after(turn_after), .blocked_pattern(blocked_pattern), .last_of_run(last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] front_pattern(input logic [4:0] blk);
    logic [3:0] p;
    casez (blk)
      5'b10???: p = P_LL;
      5'b110??: p = P_LLL;
      5'b1110?: p = P_LLLF;
      5'b11110: p = P_LLLFR;
      5'b11111: p = P_LLLFRRR;
      5'b010??: p = P_L;
      5'b0110?: p = P_LF;
      5'b01110: p = P_LFR;
      5'b01111: p = P_LFRRR;
      5'b0010?: p = P_F;
      5'b00110: p = P_FR;
      5'b00111: p = P_FRRR;
      5'b00011: p = P_RRR;
      5'b00010: p = P_R;
      5'b00001: p = P_RR;
      default:  p = NO_PATTERN;
    endcase
    return p;
  endfunction

  task automatic add_notice(input logic [2:0] kind, input logic [2:0] tb, input logic way,
                            input logic [2:0] ta, input logic [3:0] pat);
    expected_notice_t e;
    e.note.kind        = kind;
    e.note.turn_before = tb;
    e.note.travel_way  = way;
    e.note.turn_after  = ta;
    e.note.pattern     = pat;
    e.last             = 1'b0;
    expected_notices.push_back(e);
  endtask

  task automatic predict_notices(input sonar_report_t rq);
    logic [4:0] blk;
    logic any_blk, backward, one_move;
    logic [3:0] pat;
    logic [2:0] turn;
    expected_notice_t tail;
    blk = {rq.range_d < thresh_model, rq.range_a < thresh_model, rq.range_c < thresh_model,
           rq.range_b < thresh_model, rq.range_e < thresh_model};
    any_blk = |blk;
    if (rq.pending) backward = (rq.kind == ACT_TRANSLATE) && rq.amount[31];
    else backward = rq.left_speed[15] && rq.right_speed[15];
    add_notice(NOTICE_CLEAR, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
    if (backward) begin
      if (rq.side == SIDE_BACK && any_blk) begin
        if (back_trk == MODE_OFF) begin
          add_notice(NOTICE_STOP, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          back_trk = MODE_FIRST;
        end else if (back_trk == MODE_FIRST) begin
          add_notice(NOTICE_UPDATE, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          add_notice(NOTICE_MOVE, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          back_trk = MODE_EXEC;
          back_moves++;
        end
        add_notice(NOTICE_NORMAL, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
      end else if (back_trk == MODE_EXEC && !rq.pending) begin
        back_trk = MODE_OFF;
        add_notice(NOTICE_RESTART, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
      end
    end else begin
      if (rq.side == SIDE_FRONT && any_blk) begin
        if (front_trk == MODE_OFF) begin
          add_notice(NOTICE_STOP, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          front_trk = MODE_FIRST;
        end else begin
          pat = front_pattern(blk);
          add_notice(NOTICE_UPDATE, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
          if (front_trk == MODE_FIRST) begin
            one_move = 1'b0;
            case (pat)
              P_LLLFRRR, P_LFR:       begin one_move = 1'b1; turn = TURN_R_MAX; end
              P_F:                    begin one_move = 1'b1; turn = TURN_R_MIN; end
              P_LLLFR, P_LLLF, P_LF:  turn = TURN_R_MAX;
              P_LLL, P_LL, P_L:       turn = TURN_R_MED;
              P_LFRRR, P_FRRR, P_FR:  turn = TURN_L_MAX;
              P_RRR, P_RR:            turn = TURN_L_MIN;
              default:                turn = TURN_L_MED;
            endcase
            if (one_move) begin
              add_notice(NOTICE_MOVE, TURN_NONE, WAY_BACK, turn, pat);
            end else begin
              add_notice(NOTICE_MOVE, TURN_NONE, WAY_BACK, TURN_NONE, pat);
              add_notice(NOTICE_MOVE, turn, WAY_AHEAD, TURN_NONE, pat);
            end
            front_trk = MODE_EXEC;
            acted_pat = pat;
            patterns_hit[pat] = 1'b1;
          end else if (front_trk == MODE_EXEC && acted_pat != pat) begin
            front_trk = MODE_OFF;
          end
        end
        add_notice(NOTICE_NORMAL, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
      end else if (front_trk != MODE_OFF && !rq.pending) begin
        front_trk = MODE_OFF;
        add_notice(NOTICE_RESTART, TURN_NONE, WAY_AHEAD, TURN_NONE, NO_PATTERN);
      end
    end
    tail = expected_notices.pop_back();
    tail.last = 1'b1;
    expected_notices.push_back(tail);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_cnt++;
      if (error_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    expected_notice_t e;
    in_fire = in_valid && in_ready;
    out_fire = out_valid && out_ready;
    if (!rst) begin
      if (in_fire) begin
        predict_notices(cur_req);
        reports_taken++;
      end
      if (out_fire) begin
        notices_checked++;
        if (expected_notices.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: notice with nothing expected, expected none, actual kind %0d",
                     $time, notice_kind);
        end else begin
          e = expected_notices.pop_front();
          check_field("notice_kind", e.note.kind, notice_kind);
          check_field("turn_before", e.note.turn_before, turn_before);
          check_field("travel_way", e.note.travel_way, travel_way);
          check_field("turn_after", e.note.turn_after, turn_after);
          check_field("blocked_pattern", e.note.pattern, blocked_pattern);
          check_field("last_of_run", e.last, last_of_run);
        end
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (sonar_reports.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req <= sonar_reports.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] pick_range(input logic blocked, input logic [15:0] th);
    logic [15:0] v;
    if (blocked && th != 0) begin
      case ($urandom_range(0, 3))
        0:       v = 16'd0;
        1:       v = th - 16'd1;
        default: v = 16'($urandom_range(0, th - 1));
      endcase
    end else if (!blocked) begin
      case ($urandom_range(0, 3))
        0:       v = 16'hFFFF;
        1:       v = th;
        default: v = 16'($urandom_range(th, 65535));
      endcase
    end else begin
      v = 16'($urandom_range(0, 65535));
    end
    return v;
  endfunction

  function automatic sonar_report_t random_report(input logic backward, input logic side,
                                                  input logic [4:0] mask, input logic pend,
                                                  input logic [15:0] th);
    sonar_report_t r;
    r.side        = side;
    r.range_d     = pick_range(mask[4], th);
    r.range_a     = pick_range(mask[3], th);
    r.range_c     = pick_range(mask[2], th);
    r.range_b     = pick_range(mask[1], th);
    r.range_e     = pick_range(mask[0], th);
    r.pending     = pend;
    r.kind        = 2'($urandom_range(0, 3));
    r.amount      = $urandom;
    r.left_speed  = 16'($urandom_range(0, 65535));
    r.right_speed = 16'($urandom_range(0, 65535));
    if (pend) begin
      if (backward) begin
        r.kind = ACT_TRANSLATE;
        r.amount[31] = 1'b1;
      end else if (r.kind == ACT_TRANSLATE) begin
        r.amount[31] = 1'b0;
      end
    end else if (backward) begin
      r.left_speed[15] = 1'b1;
      r.right_speed[15] = 1'b1;
    end else if (r.left_speed[15] && r.right_speed[15]) begin
      if ($urandom_range(0, 1)) r.left_speed[15] = 1'b0;
      else r.right_speed[15] = 1'b0;
    end
    return r;
  endfunction

  task automatic push_fixed(input logic side, input logic [4:0] mask, input logic [15:0] lo,
                            input logic [15:0] hi, input logic pend, input logic [1:0] kind,
                            input logic [31:0] amount, input logic [15:0] ls,
                            input logic [15:0] rs);
    sonar_report_t r;
    r.side        = side;
    r.range_d     = mask[4] ? lo : hi;
    r.range_a     = mask[3] ? lo : hi;
    r.range_c     = mask[2] ? lo : hi;
    r.range_b     = mask[1] ? lo : hi;
    r.range_e     = mask[0] ? lo : hi;
    r.pending     = pend;
    r.kind        = kind;
    r.amount      = amount;
    r.left_speed  = ls;
    r.right_speed = rs;
    sonar_reports.push_back(r);
  endtask

  task automatic queue_episode(input logic [15:0] th);
    logic backward, side, home;
    logic [4:0] mask;
    int len;
    backward = 1'($urandom_range(0, 1));
    home = backward ? SIDE_BACK : SIDE_FRONT;
    mask = 5'($urandom_range(1, 31));
    len = $urandom_range(2, 5);
    repeat (len) begin
      if ($urandom_range(0, 4) == 0) mask = 5'($urandom_range(1, 31));
      side = ($urandom_range(0, 9) == 0) ? !home : home;
      sonar_reports.push_back(random_report(backward, side, mask,
                                            1'($urandom_range(0, 1)), th));
    end
    repeat ($urandom_range(1, 2))
      sonar_reports.push_back(random_report(backward, home, 5'b00000,
                                            $urandom_range(0, 3) == 0, th));
  endtask

  task automatic queue_random(input int n, input logic [15:0] th);
    int start;
    sonar_report_t r;
    start = sonar_reports.size();
    while (sonar_reports.size() - start < n) begin
      if ($urandom_range(0, 3) == 0) begin
        r = random_report(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), th);
        r.kind        = 2'($urandom_range(0, 3));
        r.amount      = $urandom;
        r.left_speed  = 16'($urandom_range(0, 65535));
        r.right_speed = 16'($urandom_range(0, 65535));
        sonar_reports.push_back(r);
      end else begin
        queue_episode(th);
      end
    end
  endtask

  task automatic drain();
    while (sonar_reports.size() != 0 || in_valid) @(posedge clk);
    while (expected_notices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] val);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESH_ADDR;
    pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    thresh_model = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    check_field("obstacle_threshold readback", val, rd[15:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] th, input int send_pct, input int recv_pct,
                           input int n, input bit squeeze);
    drain();
    write_threshold(th);
    settings_run++;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n, th);
    if (squeeze) hold_token++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // front tracker through stop, act, hold, restart
    push_fixed(SIDE_FRONT, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00000, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    // pattern change while executing, then a two-move pattern
    push_fixed(SIDE_FRONT, 5'b00100, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00100, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00010, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00010, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00010, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    // clear with an action pending holds the tracker, then restart
    push_fixed(SIDE_FRONT, 5'b00000, 16'd0, 16'hFFFF, 1'b1, ACT_ROTATE, 32'hFFFF_FFFF,
               16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00000, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    // back tracker: backing translation, then both wheels reversing
    push_fixed(SIDE_BACK, 5'b11111, 16'd0, 16'hFFFF, 1'b1, ACT_TRANSLATE, 32'h8000_0000,
               16'd0, 16'd0);
    push_fixed(SIDE_BACK, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0,
               16'h8000, 16'h8000);
    push_fixed(SIDE_BACK, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0,
               16'h8000, 16'h8000);
    // wrong ring in both directions
    push_fixed(SIDE_FRONT, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0,
               16'h8000, 16'h8000);
    push_fixed(SIDE_BACK, 5'b11111, 16'd0, 16'hFFFF, 1'b0, ACT_ROTATE, 32'd0, 16'd0, 16'd0);
    // kind three with a negative amount still means forward
    push_fixed(SIDE_FRONT, 5'b01000, 16'd0, 16'hFFFF, 1'b1, ACT_KIND3, 32'h8000_0000,
               16'h8000, 16'h8000);
    // ranges one below and exactly at the threshold
    push_fixed(SIDE_FRONT, 5'b01000, 16'd499, 16'd500, 1'b0, ACT_OTHER, 32'd0, 16'd0, 16'd0);
    push_fixed(SIDE_FRONT, 5'b00000, 16'd0, 16'hFFFF, 1'b0, ACT_OTHER, 32'h7FFF_FFFF,
               16'h7FFF, 16'h7FFF);

    run_phase(16'd500, 0, 0, 85, 1'b1);
    run_phase(16'hFFFF, 86, 0, 60, 1'b0);
    run_phase(16'd0, 0, 86, 30, 1'b0);
    run_phase(16'd1200, 35, 35, 90, 1'b0);
    run_phase(16'd1, 0, 86, 45, 1'b0);
    run_phase(16'd800, 0, 0, 75, 1'b0);
    drain();

    $display("Checked %0d notices from %0d sonar reports under %0d threshold settings.",
             notices_checked, reports_taken, settings_run);
    $display("Front patterns acted on: %0d of 15; back evasive moves: %0d.",
             $countones(patterns_hit), back_moves);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
